>>> sv/zst_pkg.sv
// shared types, command and status codes for the zonal statistics table
// no dependencies
package zst_pkg;

    localparam int ZONES_DEF = 1024;

    localparam logic [1:0] CMD_ACC   = 2'd0;
    localparam logic [1:0] CMD_EMIT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NODATA = 3'd1;
    localparam logic [2:0] ST_RANGE  = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_SAT    = 3'd4;

    localparam logic [2:0] STAT_SUM   = 3'd0;
    localparam logic [2:0] STAT_MEAN  = 3'd1;
    localparam logic [2:0] STAT_MAX   = 3'd2;
    localparam logic [2:0] STAT_MIN   = 3'd3;
    localparam logic [2:0] STAT_COUNT = 3'd4;

    localparam logic [1:0] KIND_DIRECT = 2'd0;
    localparam logic [1:0] KIND_ACC    = 2'd1;
    localparam logic [1:0] KIND_EMIT   = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] REG_STAT_TYPE    = 2'd0;
    localparam logic [1:0] REG_VALUE_NODATA = 2'd1;
    localparam logic [1:0] REG_ZONE_NODATA  = 2'd2;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [63:0] SUM_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_MIN   = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [2:0]  stat_type;
        logic [31:0] value_nodata;
        logic [15:0] zone_nodata;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  stype;
        logic [2:0]  status;
        logic [31:0] val;
        logic [15:0] zone;
    } t_entry;

    typedef struct packed {
        logic [31:0] count;
        logic [63:0] sum;
        logic [31:0] vmin;
        logic [31:0] vmax;
    } t_zrec;

endpackage

>>> sv/zst_front.sv
// front end: classifies commands and queues them for the back end
// depends on zst_pkg
module zst_front #(
    parameter int ZONES = zst_pkg::ZONES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_cmd,
    input  logic [31:0]       i_cell_value,
    input  logic [15:0]       i_zone_id,
    input  zst_pkg::t_cfg     i_cfg,
    input  logic              i_pop,
    output logic              o_busy,
    output logic              o_empty,
    output zst_pkg::t_entry   o_head
);

    zst_pkg::t_entry r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    zst_pkg::t_entry n_ent;
    logic            w_push, w_pop, w_range;

    assign o_busy  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_q[r_rp];
    assign w_push  = i_start && !o_busy;
    assign w_pop   = i_pop && !o_empty;
    assign w_range = ({1'b0, i_zone_id} >= 17'(ZONES));

    always_comb begin
        n_ent.kind   = zst_pkg::KIND_DIRECT;
        n_ent.stype  = i_cfg.stat_type;
        n_ent.status = zst_pkg::ST_OK;
        n_ent.val    = 32'd0;
        n_ent.zone   = i_zone_id;
        case (i_cmd)
            zst_pkg::CMD_ACC: begin
                if (i_cell_value == i_cfg.value_nodata || i_zone_id == i_cfg.zone_nodata) begin
                    n_ent.status = zst_pkg::ST_NODATA;
                end else if (w_range) begin
                    n_ent.status = zst_pkg::ST_RANGE;
                end else begin
                    n_ent.kind = zst_pkg::KIND_ACC;
                    n_ent.val  = i_cell_value;
                end
            end
            zst_pkg::CMD_EMIT: begin
                if (i_zone_id == i_cfg.zone_nodata) begin
                    n_ent.status = zst_pkg::ST_NODATA;
                    n_ent.val    = i_cfg.value_nodata;
                end else if (w_range) begin
                    n_ent.status = zst_pkg::ST_RANGE;
                end else begin
                    n_ent.kind = zst_pkg::KIND_EMIT;
                end
            end
            zst_pkg::CMD_CLEAR: begin
                n_ent.kind = zst_pkg::KIND_CLEAR;
            end
            default: begin
                n_ent.status = zst_pkg::ST_NODATA;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

>>> sv/zst_div.sv
// serial divider for the mean: 64-bit magnitude by 32-bit count, one bit a cycle
// depends on nothing
module zst_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_mag,
    input  logic        i_neg,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic        r_neg;
    logic [32:0] w_t;
    logic [32:0] w_diff;
    logic        w_bit;
    logic [63:0] w_qn;

    assign w_t    = {r_r, r_q[63]};
    assign w_diff = w_t - {1'b0, r_d};
    assign w_bit  = (w_t >= {1'b0, r_d});
    assign w_qn   = {r_q[62:0], w_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_mag;
            r_r   <= 32'd0;
            r_d   <= i_den;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_q <= w_qn;
            r_r <= w_bit ? w_diff[31:0] : w_t[31:0];
            if (r_cnt == 6'd63) begin
                o_quo <= r_neg ? (64'd0 - w_qn) : w_qn;
            end
        end
    end

endmodule

>>> sv/zst_back.sv
// back end: zone table memories, update, emit and clearing sweep
// depends on zst_pkg and zst_div
module zst_back #(
    parameter int ZONES = zst_pkg::ZONES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  zst_pkg::t_entry   i_head,
    output logic              o_pop,
    output logic              o_done,
    output logic [63:0]       o_stat_value,
    output logic [2:0]        o_status
);

    localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_CLR  = 3'd4;

    logic            m_valid [ZONES];
    zst_pkg::t_zrec  m_rec   [ZONES];

    logic [2:0]      r_state, n_state;
    logic [ZW-1:0]   r_addr, n_addr;
    zst_pkg::t_entry r_ent;
    logic            r_vrd;
    zst_pkg::t_zrec  r_rec;
    logic            r_rail, n_rail;
    logic            n_done;
    logic [63:0]     n_stat;
    logic [2:0]      n_status;

    logic            v_we, v_wd;
    logic [ZW-1:0]   v_wa;
    logic            d_we;
    zst_pkg::t_zrec  d_wd;
    logic [ZW-1:0]   w_ra;

    logic [63:0]     w_val64;
    logic [64:0]     w_sum_ext;
    logic [63:0]     w_sum;
    logic            w_ovf;
    logic            w_csat;
    logic            w_start_div;
    logic [63:0]     w_mag;
    logic            w_div_done;
    logic [63:0]     w_quo;

    assign w_ra      = i_head.zone[ZW-1:0];
    assign w_val64   = {{32{r_ent.val[31]}}, r_ent.val};
    assign w_sum_ext = {r_rec.sum[63], r_rec.sum} + {w_val64[63], w_val64};
    assign w_ovf     = (w_sum_ext[64] != w_sum_ext[63]);
    assign w_sum     = w_ovf ? (w_sum_ext[64] ? zst_pkg::SUM_MIN : zst_pkg::SUM_MAX)
                             : w_sum_ext[63:0];
    assign w_csat    = (r_rec.count == zst_pkg::COUNT_MAX);
    assign w_mag     = r_rec.sum[63] ? (64'd0 - r_rec.sum) : r_rec.sum;

    zst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_div),
        .i_mag   (w_mag),
        .i_neg   (r_rec.sum[63]),
        .i_den   (r_rec.count),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_rail      = r_rail;
        n_done      = 1'b0;
        n_stat      = 64'd0;
        n_status    = zst_pkg::ST_OK;
        o_pop       = 1'b0;
        v_we        = 1'b0;
        v_wa        = r_addr;
        v_wd        = 1'b0;
        d_we        = 1'b0;
        d_wd        = r_rec;
        w_start_div = 1'b0;
        case (r_state)
            S_INIT, S_CLR: begin
                v_we = 1'b1;
                if (r_addr == ZW'(ZONES - 1)) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                    n_done  = (r_state == S_CLR);
                end else begin
                    n_addr = r_addr + ZW'(1);
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_head.kind)
                        zst_pkg::KIND_DIRECT: begin
                            n_done   = 1'b1;
                            n_stat   = {{32{i_head.val[31]}}, i_head.val};
                            n_status = i_head.status;
                        end
                        zst_pkg::KIND_CLEAR: begin
                            n_state = S_CLR;
                            n_addr  = '0;
                        end
                        default: begin
                            n_state = S_EXEC;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                v_wa    = r_ent.zone[ZW-1:0];
                if (r_ent.kind == zst_pkg::KIND_ACC) begin
                    n_done = 1'b1;
                    v_we   = 1'b1;
                    v_wd   = 1'b1;
                    d_we   = 1'b1;
                    if (!r_vrd) begin
                        d_wd.count = 32'd1;
                        d_wd.sum   = w_val64;
                        d_wd.vmin  = r_ent.val;
                        d_wd.vmax  = r_ent.val;
                    end else begin
                        d_wd.count = w_csat ? r_rec.count : r_rec.count + 32'd1;
                        d_wd.sum   = w_sum;
                        d_wd.vmin  = ($signed(r_ent.val) < $signed(r_rec.vmin)) ?
                                     r_ent.val : r_rec.vmin;
                        d_wd.vmax  = ($signed(r_ent.val) > $signed(r_rec.vmax)) ?
                                     r_ent.val : r_rec.vmax;
                        if (w_csat || w_ovf) begin
                            n_status = zst_pkg::ST_SAT;
                        end
                    end
                end else if (!r_vrd) begin
                    n_done   = 1'b1;
                    n_status = zst_pkg::ST_EMPTY;
                end else begin
                    n_rail = w_csat || r_rec.sum == zst_pkg::SUM_MAX
                             || r_rec.sum == zst_pkg::SUM_MIN;
                    n_done = 1'b1;
                    case (r_ent.stype)
                        zst_pkg::STAT_SUM:   n_stat = r_rec.sum;
                        zst_pkg::STAT_MAX:   n_stat = {{32{r_rec.vmax[31]}}, r_rec.vmax};
                        zst_pkg::STAT_MIN:   n_stat = {{32{r_rec.vmin[31]}}, r_rec.vmin};
                        zst_pkg::STAT_COUNT: n_stat = {32'd0, r_rec.count};
                        zst_pkg::STAT_MEAN: begin
                            n_done      = 1'b0;
                            w_start_div = 1'b1;
                            n_state     = S_DIV;
                        end
                        default: begin
                            n_rail   = 1'b0;
                            n_status = zst_pkg::ST_NODATA;
                        end
                    endcase
                    if (n_rail) begin
                        n_status = zst_pkg::ST_SAT;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_done   = 1'b1;
                    n_stat   = w_quo;
                    n_status = r_rail ? zst_pkg::ST_SAT : zst_pkg::ST_OK;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            m_valid[v_wa] <= v_wd;
        end
        if (d_we) begin
            m_rec[v_wa] <= d_wd;
        end
        r_vrd <= m_valid[w_ra];
        r_rec <= m_rec[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head;
        end
        o_stat_value <= n_stat;
        o_status     <= n_status;
        r_rail       <= n_rail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_addr  <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            o_done  <= n_done;
        end
    end

endmodule

>>> sv/zonal_statistics_table.sv
// zonal statistics table: per-zone count, sum, min, max with sum, mean, max, min, count emit
// the back end serves a two-deep queue one item at a time; direct results go straight out,
// accumulate and emit pass S_EXEC, mean then waits in S_DIV for the divider, clear sweeps every zone
// after reset a sweep over all ZONES entries clears the valid memory; queued items wait for it
// results are strobed by o_done for one cycle; the receiver cannot stall
// depends on zst_pkg, zst_front, zst_back, zst_div
module zonal_statistics_table #(
    parameter int ZONES = zst_pkg::ZONES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_cell_value,
    input  logic [15:0] i_zone_id,
    output logic        o_done,
    output logic [63:0] o_stat_value,
    output logic [2:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    zst_pkg::t_cfg   r_cfg;
    zst_pkg::t_entry w_head;
    logic            w_empty, w_pop, w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stat_type    <= 3'd0;
            r_cfg.value_nodata <= 32'd0;
            r_cfg.zone_nodata  <= 16'hFFFF;
        end else if (w_wr) begin
            case (paddr[3:2])
                zst_pkg::REG_STAT_TYPE:    r_cfg.stat_type    <= pwdata[2:0];
                zst_pkg::REG_VALUE_NODATA: r_cfg.value_nodata <= pwdata;
                zst_pkg::REG_ZONE_NODATA:  r_cfg.zone_nodata  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            zst_pkg::REG_STAT_TYPE:    prdata = {29'd0, r_cfg.stat_type};
            zst_pkg::REG_VALUE_NODATA: prdata = r_cfg.value_nodata;
            zst_pkg::REG_ZONE_NODATA:  prdata = {16'd0, r_cfg.zone_nodata};
            default:                   prdata = 32'd0;
        endcase
    end

    zst_front #(.ZONES(ZONES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (i_cmd),
        .i_cell_value (i_cell_value),
        .i_zone_id    (i_zone_id),
        .i_cfg        (r_cfg),
        .i_pop        (w_pop),
        .o_busy       (busy),
        .o_empty      (w_empty),
        .o_head       (w_head)
    );

    zst_back #(.ZONES(ZONES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_done       (o_done),
        .o_stat_value (o_stat_value),
        .o_status     (o_status)
    );

endmodule
